// ===== rtl/auto_backlight_from_light_sensor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for auto_backlight_from_light_sensor
// Clocked assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AUTO_BACKLIGHT_FROM_LIGHT_SENSOR_ASSERT_SVH
`define AUTO_BACKLIGHT_FROM_LIGHT_SENSOR_ASSERT_SVH

`ifndef SYNTH

// check a property on every rising clock edge outside reset
`define ABL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every rising clock edge, reset included
`define ABL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ABL_ASSERT(label, prop, msg)
`define ABL_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/abl_pkg.sv =====
// ----------------------------------------------------------------------------
// abl_pkg
// Widths, constants and the backlight level table of the auto backlight block.
// ----------------------------------------------------------------------------
package abl_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 14;
    localparam int PCT_W    = 7;
    localparam int LEVEL_W  = 8;
    localparam int SCALE_W  = 19;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SCALE_W-1:0]  PCT_SPAN   = 19'd90;
    localparam logic [PCT_W-1:0]    PCT_MIN    = 7'd10;
    localparam logic [PCT_W-1:0]    PCT_MAX    = 7'd100;
    localparam logic [PCT_W-1:0]    PCT_RESET  = 7'd80;
    localparam logic [PCT_W-1:0]    HYSTERESIS = 7'd2;
    localparam logic [LEVEL_W-1:0]  LEVEL_MIN  = 8'd25;

    // reciprocal of three, exact for sums below 2^16
    localparam int               RECIP3_SHIFT = 17;
    localparam logic [16:0]      RECIP3       = 17'd43691;

    typedef logic [LEVEL_W-1:0] level_lut_t [128];

    function automatic level_lut_t build_level_lut();
        level_lut_t lut;
        int         c;
        for (int p = 0; p < 128; p++)
        begin
            c = p;
            if (c < 10)
            begin
                c = 10;
            end
            if (c > 100)
            begin
                c = 100;
            end
            lut[p] = LEVEL_W'(25 + ((c - 10) * 230) / 90);
        end
        return lut;
    endfunction

    localparam level_lut_t LEVEL_LUT = build_level_lut();

endpackage

// ===== rtl/abl_if.sv =====
// ----------------------------------------------------------------------------
// abl_if
// Valid/ready channels: sensor beats in, brightness result beats out.
// ----------------------------------------------------------------------------
interface abl_sensor_if
    import abl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;

    modport source (output valid, output sample_a, output sample_b,
                    output sample_c, output sample_d, input ready);
    modport sink   (input valid, input sample_a, input sample_b,
                    input sample_c, input sample_d, output ready);
endinterface

interface abl_result_if
    import abl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                updated;
    logic [PCT_W-1:0]    brightness_pct;
    logic [LEVEL_W-1:0]  backlight_level;
    logic [SAMPLE_W-1:0] smoothed_out;

    modport source (output valid, output updated, output brightness_pct,
                    output backlight_level, output smoothed_out, input ready);
    modport sink   (input valid, input updated, input brightness_pct,
                    input backlight_level, input smoothed_out, output ready);
endinterface

// ===== rtl/auto_backlight_from_light_sensor.sv =====
// ----------------------------------------------------------------------------
// auto_backlight_from_light_sensor
// Sensor averaging, exponential smoothing and hysteresis on backlight brightness.
// ----------------------------------------------------------------------------
// Takes one sensor beat per clock while the result side is ready and returns
// one result beat for each, through the input register and then the result
// register. The mean of the samples is formed and held in an input register;
// the smoothing, the percentage mapping, the hysteresis check and the level
// table all sit between it and the result register, so the sustained rate is
// one beat per cycle, limited only by back-pressure on the result channel.
// Write auto_enable through cfg_we/cfg_wdata only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "auto_backlight_from_light_sensor_assert.svh"

module auto_backlight_from_light_sensor
    import abl_pkg::*;
#(
    parameter int SAMPLES_PER_UPDATE = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    abl_sensor_if.sink   sensor,
    abl_result_if.source result
);

    localparam int N_USED = (SAMPLES_PER_UPDATE < 1) ? 1 :
                            (SAMPLES_PER_UPDATE > 4) ? 4 : SAMPLES_PER_UPDATE;
    localparam int LOG_N  = $clog2(N_USED);

    logic                auto_en_reg;
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] raw_reg;
    logic [SAMPLE_W-1:0] smooth_reg;
    logic                seeded_reg;
    logic [PCT_W-1:0]    bright_reg;
    logic                out_valid_reg;
    logic                res_updated_reg;
    logic [PCT_W-1:0]    res_pct_reg;
    logic [LEVEL_W-1:0]  res_level_reg;
    logic [SAMPLE_W-1:0] res_smooth_reg;

    logic [SUM_W-1:0]    sum;
    logic [30:0]         prod3;
    logic [SAMPLE_W-1:0] raw_in;
    logic                advance;
    logic                accept;
    logic [SAMPLE_W-1:0] old_level;
    logic [SUM_W-1:0]    old_x3;
    logic [SAMPLE_W-1:0] smooth_calc;
    logic [SCALE_W-1:0]  scaled;
    logic [PCT_W-1:0]    quot0;
    logic [12:0]         rem;
    logic [PCT_W-1:0]    target;
    logic [PCT_W-1:0]    diff;
    logic                change;
    logic [SAMPLE_W-1:0] smooth_next;
    logic                seeded_next;
    logic [PCT_W-1:0]    bright_next;
    logic                updated_next;

    // mean of the samples in use
    always_comb
    begin
        sum = SUM_W'(sensor.sample_a);
        if (N_USED >= 2)
        begin
            sum = sum + SUM_W'(sensor.sample_b);
        end
        if (N_USED >= 3)
        begin
            sum = sum + SUM_W'(sensor.sample_c);
        end
        if (N_USED >= 4)
        begin
            sum = sum + SUM_W'(sensor.sample_d);
        end
        prod3 = 31'(sum) * 31'(RECIP3);
        if (N_USED == 3)
        begin
            raw_in = prod3[RECIP3_SHIFT +: SAMPLE_W];
        end
        else
        begin
            raw_in = SAMPLE_W'(sum >> LOG_N);
        end
    end

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sensor.ready = !s1_valid_reg || advance;
    assign accept       = sensor.valid && sensor.ready;

    // smoothing, percentage mapping and hysteresis
    always_comb
    begin
        old_level   = seeded_reg ? smooth_reg : raw_reg;
        old_x3      = {1'b0, old_level, 1'b0} + SUM_W'(old_level);
        smooth_calc = old_x3[SUM_W-1:2] + SAMPLE_W'(raw_reg[SAMPLE_W-1:2]);

        // divide by 4095: estimate by 4096, then one correction step
        scaled = SCALE_W'(FULL_SCALE - smooth_calc) * PCT_SPAN;
        quot0  = scaled[SCALE_W-1:SAMPLE_W];
        rem    = 13'(scaled[SAMPLE_W-1:0]) + 13'(quot0);
        if (rem >= 13'(FULL_SCALE))
        begin
            target = PCT_MIN + quot0 + 7'd1;
        end
        else
        begin
            target = PCT_MIN + quot0;
        end

        diff   = (target > bright_reg) ? (target - bright_reg) : (bright_reg - target);
        change = diff > HYSTERESIS;

        smooth_next  = smooth_reg;
        seeded_next  = seeded_reg;
        bright_next  = bright_reg;
        updated_next = 1'b0;
        if (auto_en_reg)
        begin
            smooth_next = smooth_calc;
            seeded_next = 1'b1;
            if (change)
            begin
                bright_next  = target;
                updated_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_en_reg   <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            smooth_reg    <= '0;
            seeded_reg    <= 1'b0;
            bright_reg    <= PCT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                auto_en_reg <= cfg_wdata;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                smooth_reg    <= smooth_next;
                seeded_reg    <= seeded_next;
                bright_reg    <= bright_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= raw_in;
        end
        if (advance)
        begin
            res_updated_reg <= updated_next;
            res_pct_reg     <= bright_next;
            res_level_reg   <= LEVEL_LUT[bright_next];
            res_smooth_reg  <= smooth_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.updated         = res_updated_reg;
    assign result.brightness_pct  = res_pct_reg;
    assign result.backlight_level = res_level_reg;
    assign result.smoothed_out    = res_smooth_reg;

    `ABL_ASSERT(a_pct_range, (bright_reg >= PCT_MIN && bright_reg <= PCT_MAX), "brightness out of range")
    `ABL_ASSERT(a_hold_when_off, (advance && !auto_en_reg) |=> ($stable(bright_reg) && $stable(smooth_reg)), "state moved with auto mode off")
    `ABL_ASSERT(a_stage_hold, (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(raw_reg)), "input stage lost a beat")
    `ABL_ASSERT(a_level_min, (out_valid_reg) |-> (res_level_reg >= LEVEL_MIN), "backlight level below minimum")
    `ABL_ASSERT(a_update_moves, (advance && updated_next) |=> !$stable(bright_reg), "update without brightness change")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for auto_backlight_from_light_sensor. Sensor beats come
// from a queue filled by the stimulus process. Each accepted beat is run
// through a local smoothing and hysteresis predictor, and every result beat
// is checked field by field against the oldest prediction. Idle bursts on
// both channels are random, and auto mode is toggled between phases.
// ----------------------------------------------------------------------------
module tb;
    import abl_pkg::*;

    localparam int SAMPLES_PER_UPDATE = 4;
    localparam int QUIET_LIMIT        = 1000;
    localparam int PHASE_BEATS        = 200;
    localparam int PHASE_COUNT        = 8;

    typedef logic [3:0][SAMPLE_W-1:0] sample_set_t;

    typedef struct packed {
        logic                updated;
        logic [PCT_W-1:0]    pct;
        logic [LEVEL_W-1:0]  level;
        logic [SAMPLE_W-1:0] avg;
    } backlight_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    abl_sensor_if sensor_ch ();
    abl_result_if result_ch ();

    auto_backlight_from_light_sensor #(
        .SAMPLES_PER_UPDATE(SAMPLES_PER_UPDATE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .sensor   (sensor_ch),
        .result   (result_ch)
    );

    sample_set_t     pending_sets[$];
    backlight_beat_t expected_beats[$];
    sample_set_t     next_set;
    backlight_beat_t got_beat;
    backlight_beat_t want_beat;

    bit auto_on;
    bit seeded;
    int avg_level;
    int bright_pct;

    bit calm;
    int src_idle;
    int sink_idle;
    int quiet_cycles;
    int failures;

    always #1 clk = ~clk;

    function automatic backlight_beat_t predict_backlight(sample_set_t s);
        backlight_beat_t r;
        int n;
        int total;
        int raw;
        int target;
        int gap;
        int pct;
        r.updated = 1'b0;
        if (auto_on)
        begin
            n = SAMPLES_PER_UPDATE;
            if (n < 1)
            begin
                n = 1;
            end
            if (n > 4)
            begin
                n = 4;
            end
            total = 0;
            for (int i = 0; i < n; i++)
            begin
                total += s[i];
            end
            raw = total / n;
            if (!seeded)
            begin
                avg_level = raw;
                seeded    = 1'b1;
            end
            avg_level = ((avg_level * 3) / 4 + raw / 4) & 12'hFFF;
            target    = 10 + ((4095 - avg_level) * 90) / 4095;
            gap       = (target > bright_pct) ? target - bright_pct : bright_pct - target;
            if (gap > 2)
            begin
                bright_pct = target;
                r.updated  = 1'b1;
            end
        end
        pct = bright_pct;
        if (pct < 10)
        begin
            pct = 10;
        end
        if (pct > 100)
        begin
            pct = 100;
        end
        r.pct   = PCT_W'(bright_pct);
        r.level = LEVEL_W'(25 + ((pct - 10) * 230) / 90);
        r.avg   = SAMPLE_W'(avg_level);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] jitter_sample(int base, int spread);
        int v;
        v = base - spread;
        v += int'($urandom_range(0, 2 * spread));
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 4095)
        begin
            v = 4095;
        end
        return SAMPLE_W'(v);
    endfunction

    task automatic queue_set(int a, int b, int c, int d);
        sample_set_t s;
        s[0] = SAMPLE_W'(a);
        s[1] = SAMPLE_W'(b);
        s[2] = SAMPLE_W'(c);
        s[3] = SAMPLE_W'(d);
        pending_sets.push_back(s);
    endtask

    task automatic wait_idle();
        while (pending_sets.size() != 0 || sensor_ch.valid || expected_beats.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_auto_enable(bit v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        auto_on = v;
    endtask

    // sensor driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sensor_ch.valid <= 1'b0;
        end
        else if (!sensor_ch.valid || sensor_ch.ready)
        begin
            if (src_idle > 0)
            begin
                src_idle--;
                sensor_ch.valid <= 1'b0;
            end
            else if (pending_sets.size() > 0)
            begin
                next_set = pending_sets.pop_front();
                sensor_ch.valid    <= 1'b1;
                sensor_ch.sample_a <= next_set[0];
                sensor_ch.sample_b <= next_set[1];
                sensor_ch.sample_c <= next_set[2];
                sensor_ch.sample_d <= next_set[3];
                if (!calm && $urandom_range(0, 9) == 0)
                begin
                    src_idle = $urandom_range(1, 15);
                end
            end
            else
            begin
                sensor_ch.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (sink_idle > 0)
        begin
            sink_idle--;
            result_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            sink_idle = $urandom_range(0, 14);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got_beat = {result_ch.updated, result_ch.brightness_pct,
                            result_ch.backlight_level, result_ch.smoothed_out};
                if (expected_beats.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("unexpected result beat: upd=%0d pct=%0d lvl=%0d avg=%0d",
                                 got_beat.updated, got_beat.pct, got_beat.level,
                                 got_beat.avg);
                    end
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    if (got_beat !== want_beat)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("mismatch at %0t: expected upd=%0d pct=%0d lvl=%0d avg=%0d, got upd=%0d pct=%0d lvl=%0d avg=%0d",
                                     $realtime, want_beat.updated, want_beat.pct,
                                     want_beat.level, want_beat.avg, got_beat.updated,
                                     got_beat.pct, got_beat.level, got_beat.avg);
                        end
                    end
                end
            end
            if (sensor_ch.valid && sensor_ch.ready)
            begin
                expected_beats.push_back(predict_backlight({sensor_ch.sample_d,
                    sensor_ch.sample_c, sensor_ch.sample_b, sensor_ch.sample_a}));
            end
            if ((sensor_ch.valid && sensor_ch.ready) || (result_ch.valid && result_ch.ready)
                || cfg_we)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int base;
        int spread;
        int run_len;
        int queued;
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        sensor_ch.valid    = 1'b0;
        sensor_ch.sample_a = '0;
        sensor_ch.sample_b = '0;
        sensor_ch.sample_c = '0;
        sensor_ch.sample_d = '0;
        result_ch.ready    = 1'b0;
        auto_on            = 1'b1;
        seeded             = 1'b0;
        avg_level          = 0;
        bright_pct         = 80;
        calm               = 1'b0;
        src_idle           = 0;
        sink_idle          = 0;
        quiet_cycles       = 0;
        failures           = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // auto mode off before the average is seeded
        write_auto_enable(1'b0);
        queue_set(0, 0, 0, 0);
        queue_set(4095, 4095, 4095, 4095);
        queue_set(12'hAAA, 12'h555, 12'hAAA, 12'h555);
        wait_idle();

        write_auto_enable(1'b1);
        queue_set(0, 0, 0, 0);
        queue_set(4095, 4095, 4095, 4094);
        repeat (12)
        begin
            queue_set(4095, 4095, 4095, 4095);
        end
        queue_set(12'hAAA, 12'h555, 12'hAAA, 12'h555);
        queue_set(12'h555, 12'hAAA, 12'h555, 12'hAAA);
        queue_set(0, 4095, 0, 4095);
        queue_set(1, 2, 3, 3);
        queue_set(2048, 2048, 2048, 2048);
        queue_set(2048, 2049, 2047, 2048);
        queue_set(0, 0, 0, 0);
        queue_set(0, 0, 0, 0);
        wait_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_auto_enable(!(phase == 2 || phase == 5));
            calm = (phase == PHASE_COUNT - 1);
            queued = 0;
            while (queued < PHASE_BEATS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_set($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095));
                    queued++;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: base = 0;
                        1: base = 4095;
                        default: base = $urandom_range(0, 4095);
                    endcase
                    case ($urandom_range(0, 3))
                        0: spread = 0;
                        1: spread = 3;
                        2: spread = 40;
                        default: spread = 400;
                    endcase
                    run_len = $urandom_range(1, 40);
                    for (int k = 0; k < run_len && queued < PHASE_BEATS; k++)
                    begin
                        queue_set(jitter_sample(base, spread), jitter_sample(base, spread),
                                  jitter_sample(base, spread), jitter_sample(base, spread));
                        queued++;
                    end
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            failures++;
        end
        if (failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
